// ===== hdl/u8d_pkg.sv =====
// u8d_pkg: types and constants shared by the utf-8 byte stream decoder
// no dependencies; imported by the interfaces, the step logic and the top level
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 16;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned PEND_W  = 2;

    // top two bits of a byte
    localparam logic [1:0] TOP_CONT = 2'b10;
    localparam logic [1:0] TOP_LEAD = 2'b11;

    localparam logic [5:0] CONT_PAYLOAD_MASK = 6'h3F;
    localparam logic [4:0] LEAD2_MASK        = 5'h1F;
    localparam logic [3:0] LEAD3_MASK        = 4'h0F;
    localparam logic [2:0] LEAD4_MASK        = 3'h07;

    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;

    localparam logic [LEN_W-1:0] LEN_SINGLE = 3'd1;
    localparam logic [LEN_W-1:0] LEN_ERROR  = 3'd0;

    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   accumulator;
        logic [LEN_W-1:0]  sequence_total;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             bad_sequence;
    } dec_result_t;

endpackage

`default_nettype wire

// ===== hdl/u8d_if.sv =====
// u8d_if: valid/ready channel interfaces for byte input and decoded results
// depends on u8d_pkg for field widths
`default_nettype none

interface u8d_byte_if
    import u8d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_result_if
    import u8d_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_sequence;

    modport source (output valid, output code_point, output seq_length,
                    output bad_sequence, input ready);
    modport sink   (input valid, input code_point, input seq_length,
                    input bad_sequence, output ready);
endinterface

`default_nettype wire

// ===== hdl/u8d_step.sv =====
// u8d_step: next-state and result logic for one byte of the utf-8 stream
// depends on u8d_pkg
`default_nettype none

module u8d_step
    import u8d_pkg::*;
(
    input  wire dec_state_t       state,
    input  wire [BYTE_W-1:0]      byte_in,
    output dec_state_t            state_next,
    output logic                  res_valid,
    output dec_result_t           res
);

    logic [1:0]        top;
    logic [CP_W-1:0]   acc_shift;
    logic [PEND_W-1:0] pend_dec;
    dec_result_t       err_res;

    assign top       = byte_in[7:6];
    assign acc_shift = {state.accumulator[CP_W-7:0], byte_in[5:0] & CONT_PAYLOAD_MASK};
    assign pend_dec  = state.bytes_pending - PEND_ONE;
    assign err_res   = '{code_point: '0, seq_length: LEN_ERROR, bad_sequence: 1'b1};

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        if (state.bytes_pending != PEND_NONE)
        begin
            if (top != TOP_CONT)
            begin
                state_next = '0;
                res_valid  = 1'b1;
                res        = err_res;
            end
            else if (pend_dec == PEND_NONE)
            begin
                state_next = '0;
                res_valid  = 1'b1;
                res        = '{code_point: acc_shift, seq_length: state.sequence_total,
                               bad_sequence: 1'b0};
            end
            else
            begin
                state_next.accumulator   = acc_shift;
                state_next.bytes_pending = pend_dec;
            end
        end
        else
        begin
            case (top)
                TOP_CONT:
                begin
                    state_next = '0;
                    res_valid  = 1'b1;
                    res        = err_res;
                end
                TOP_LEAD:
                begin
                    if (!byte_in[5])
                    begin
                        state_next = '{bytes_pending: PEND_ONE,
                                       accumulator: {11'd0, byte_in[4:0] & LEAD2_MASK},
                                       sequence_total: {1'b0, PEND_ONE} + LEN_SINGLE};
                    end
                    else if (!byte_in[4])
                    begin
                        state_next = '{bytes_pending: PEND_TWO,
                                       accumulator: {12'd0, byte_in[3:0] & LEAD3_MASK},
                                       sequence_total: {1'b0, PEND_TWO} + LEN_SINGLE};
                    end
                    else if (!byte_in[3])
                    begin
                        state_next = '{bytes_pending: PEND_THREE,
                                       accumulator: {13'd0, byte_in[2:0] & LEAD4_MASK},
                                       sequence_total: {1'b0, PEND_THREE} + LEN_SINGLE};
                    end
                    else
                    begin
                        state_next = '0;
                        res_valid  = 1'b1;
                        res        = err_res;
                    end
                end
                default:
                begin
                    state_next = '0;
                    res_valid  = 1'b1;
                    res        = '{code_point: {8'd0, byte_in}, seq_length: LEN_SINGLE,
                                   bad_sequence: 1'b0};
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_byte_stream_decoder.sv =====
// utf8_byte_stream_decoder: usage
// in_stream carries one raw byte per transaction; out_stream carries one
// decoded code point (low 16 bits), its sequence length and an error flag.
// a lead byte or a non-final continuation byte produces no output; the final
// byte of a sequence, a single ascii byte or any malformed byte produces one.
// the result of a byte is registered and appears on out_stream in the cycle
// after the byte is accepted (one output register after the decode logic).
// throughput: one byte per cycle; in_stream.ready stays high while the
// output register is empty or being drained in the same cycle.
// when the receiver stalls, the result holds in the output register and
// in_stream.ready drops only if that register is full and not taken.
// reset clears the decode state to idle and empties the output register.
// depends on u8d_pkg, u8d_if and u8d_step
`default_nettype none

module utf8_byte_stream_decoder
    import u8d_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    u8d_byte_if.sink       in_stream,
    u8d_result_if.source   out_stream
);

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res_reg;
    dec_result_t res_next;
    logic        res_valid;
    logic        out_valid_reg;
    logic        in_fire;

    u8d_step u_step (
        .state      (state_reg),
        .byte_in    (in_stream.byte_in),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res_next)
    );

    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign in_fire         = in_stream.valid && in_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_stream.ready)
            begin
                out_valid_reg <= in_fire && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.code_point   = res_reg.code_point;
    assign out_stream.seq_length   = res_reg.seq_length;
    assign out_stream.bad_sequence = res_reg.bad_sequence;

endmodule

`default_nettype wire

// ===== hdl/u8d_checker.sv =====
// u8d_checker: port-level assertions for the utf-8 byte stream decoder
// depends on u8d_pkg; bound to utf8_byte_stream_decoder below
`default_nettype none

module u8d_checker
    import u8d_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             in_valid,
    input wire             in_ready,
    input wire             out_valid,
    input wire             out_ready,
    input wire [CP_W-1:0]  code_point,
    input wire [LEN_W-1:0] seq_length,
    input wire             bad_sequence
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(seq_length) && $stable(bad_sequence))
        else $error("stalled result changed");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_sequence |-> code_point == '0 && seq_length == LEN_ERROR)
        else $error("error result with nonzero fields");

    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_sequence |-> seq_length != LEN_ERROR && seq_length <= 3'd4)
        else $error("bad sequence length");

    a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_sequence && seq_length == LEN_SINGLE |-> code_point < 16'd128)
        else $error("single byte result above ascii range");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without accepted byte");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_stream.valid),
    .in_ready     (in_stream.ready),
    .out_valid    (out_stream.valid),
    .out_ready    (out_stream.ready),
    .code_point   (out_stream.code_point),
    .seq_length   (out_stream.seq_length),
    .bad_sequence (out_stream.bad_sequence)
);

`default_nettype wire

// ===== tb/utf8_byte_stream_decoder_test.sv =====
// utf8_byte_stream_decoder_test: self-checking bench for the utf-8 byte stream decoder
// drives raw bytes with random gaps, predicts each decoded result and checks it on take
// depends on u8d_pkg, u8d_if and the utf8_byte_stream_decoder rtl
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_test;
    import u8d_pkg::*;

    localparam int RANDOM_BYTES = 730;
    localparam int CALM_BYTES   = 100;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 1000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    u8d_byte_if   byte_chan ();
    u8d_result_if result_chan ();

    utf8_byte_stream_decoder u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (byte_chan),
        .out_stream (result_chan)
    );

    logic [BYTE_W-1:0] stream_bytes[$];
    dec_result_t       expected_results[$];

    // decoder state as predicted
    logic [PEND_W-1:0] cont_left   = PEND_NONE;
    logic [CP_W-1:0]   cp_accum    = '0;
    logic [LEN_W-1:0]  open_length = LEN_ERROR;

    int bytes_accepted = 0;
    int results_taken  = 0;
    int mismatch_count = 0;
    int total_bytes    = 0;
    int send_gap       = 0;
    int recv_stall     = 0;
    int recv_hold      = 0;
    bit hold_done      = 1'b0;
    bit calm_tail      = 1'b0;

    logic              next_valid;
    logic [BYTE_W-1:0] next_byte;
    dec_result_t       want;

    always #5 clk = ~clk;

    task automatic decode_step(input logic [BYTE_W-1:0] b);
        dec_result_t res;
        bit          emit;
        res  = '0;
        emit = 1'b0;
        if (cont_left != PEND_NONE && b[7:6] == TOP_CONT)
        begin
            cp_accum  = {cp_accum[CP_W-7:0], b[5:0] & CONT_PAYLOAD_MASK};
            cont_left = cont_left - 1'b1;
            if (cont_left == PEND_NONE)
            begin
                emit           = 1'b1;
                res.code_point = cp_accum;
                res.seq_length = open_length;
            end
        end
        else if (cont_left != PEND_NONE || b[7:6] == TOP_CONT || (&b[7:3]))
        begin
            // missing continuation, stray continuation or invalid lead
            emit             = 1'b1;
            res.bad_sequence = 1'b1;
        end
        else if (b[7:6] != TOP_LEAD)
        begin
            emit           = 1'b1;
            res.code_point = CP_W'(b);
            res.seq_length = LEN_SINGLE;
        end
        else
        begin
            if (!b[5])
            begin
                cp_accum  = CP_W'(b[4:0] & LEAD2_MASK);
                cont_left = PEND_ONE;
            end
            else if (!b[4])
            begin
                cp_accum  = CP_W'(b[3:0] & LEAD3_MASK);
                cont_left = PEND_TWO;
            end
            else
            begin
                cp_accum  = CP_W'(b[2:0] & LEAD4_MASK);
                cont_left = PEND_THREE;
            end
            open_length = LEN_W'(cont_left) + 1'b1;
        end
        if (emit)
        begin
            cont_left   = PEND_NONE;
            cp_accum    = '0;
            open_length = LEN_ERROR;
            expected_results.push_back(res);
        end
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_chan.valid   <= 1'b0;
            byte_chan.byte_in <= '0;
            calm_tail         <= 1'b0;
        end
        else if (!byte_chan.valid || byte_chan.ready)
        begin
            if (byte_chan.valid)
            begin
                decode_step(byte_chan.byte_in);
                bytes_accepted++;
            end
            next_valid = 1'b0;
            next_byte  = byte_chan.byte_in;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (stream_bytes.size() > 0)
            begin
                next_valid = 1'b1;
                next_byte  = stream_bytes.pop_front();
                if (stream_bytes.size() > CALM_BYTES && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            byte_chan.valid   <= next_valid;
            byte_chan.byte_in <= next_byte;
            calm_tail         <= (stream_bytes.size() <= CALM_BYTES);
        end
    end

    // one long receiver hold so the output register fills and input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_hold <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_taken >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            recv_hold <= HOLD_CYCLES;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_chan.ready <= 1'b0;
        end
        else
        begin
            if (result_chan.valid && result_chan.ready)
            begin
                results_taken++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected transaction: code_point %h seq_length %0d bad %0b",
                           result_chan.code_point, result_chan.seq_length,
                           result_chan.bad_sequence);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_chan.code_point !== want.code_point)
                    begin
                        mismatch_count++;
                        $error("code_point: expected %h, actual %h",
                               want.code_point, result_chan.code_point);
                    end
                    if (result_chan.seq_length !== want.seq_length)
                    begin
                        mismatch_count++;
                        $error("seq_length: expected %0d, actual %0d",
                               want.seq_length, result_chan.seq_length);
                    end
                    if (result_chan.bad_sequence !== want.bad_sequence)
                    begin
                        mismatch_count++;
                        $error("bad_sequence: expected %0b, actual %0b",
                               want.bad_sequence, result_chan.bad_sequence);
                    end
                end
            end
            if (recv_hold > 0)
            begin
                result_chan.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_chan.ready <= 1'b0;
            end
            else
            begin
                result_chan.ready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 5) == 0)
                    recv_stall = $urandom_range(1, 5);
            end
        end
    end

    initial
    begin
        int                kind;
        int                seq_len;
        int                n_cont;
        int                drain;
        bit                broken;
        logic [BYTE_W-1:0] b;

        byte_chan.valid   = 1'b0;
        byte_chan.byte_in = '0;
        result_chan.ready = 1'b0;

        // ascii extremes, each sequence length, stray continuations, invalid leads,
        // missing continuations that swallow the next byte, an overlong form
        stream_bytes = '{8'h00, 8'h7F,
                         8'hC2, 8'hA9,
                         8'hE2, 8'h82, 8'hAC,
                         8'hF0, 8'h9F, 8'h98, 8'h80,
                         8'hF7, 8'hBF, 8'hBF, 8'hBF,
                         8'h80, 8'hBF,
                         8'hF8, 8'hFF,
                         8'hC3, 8'h41,
                         8'hE0, 8'h80, 8'hC0,
                         8'hC0, 8'h80};

        while (stream_bytes.size() < RANDOM_BYTES + 26)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 9)
            begin
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                broken  = (kind >= 7);
                seq_len = $urandom_range(broken ? 2 : 1, 4);
                case (seq_len)
                    1:       b = 8'($urandom_range(0, 127));
                    2:       b = 8'hC0 | 8'($urandom_range(0, 31));
                    3:       b = 8'hE0 | 8'($urandom_range(0, 15));
                    default: b = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                stream_bytes.push_back(b);
                n_cont = broken ? $urandom_range(0, seq_len - 2) : seq_len - 1;
                repeat (n_cont)
                    stream_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
                if (broken)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == TOP_CONT)
                        b[6] = 1'b1;
                    stream_bytes.push_back(b);
                end
            end
        end
        total_bytes = stream_bytes.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < total_bytes)
            @(posedge clk);
        drain = 0;
        while (expected_results.size() > 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (5) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            mismatch_count++;
            $error("%0d expected transactions never arrived", expected_results.size());
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
